FILE: rtl/fwet_pkg.sv
`default_nettype none

package fwet_pkg;

  // Wheel order: front right, front left, back right, back left
  localparam int WHEELS        = 4;
  localparam int COUNT_WIDTH   = 16;
  localparam int CMD_WIDTH     = 2;
  localparam int ELAPSED_WIDTH = 32;
  localparam int CPR_WIDTH     = 12;
  localparam int RPM_WIDTH     = 20;

  // Speed numerator scale: ms per minute times 16 (4 fraction bits)
  localparam int SCALE_WIDTH = 20;
  localparam logic [SCALE_WIDTH-1:0] SCALE = SCALE_WIDTH'(60000 * 16);

  // Numerator count*SCALE and denominator cpr*elapsed
  localparam int NUM_WIDTH = COUNT_WIDTH + SCALE_WIDTH;
  localparam int HI_WIDTH  = NUM_WIDTH - RPM_WIDTH;
  localparam int DEN_WIDTH = CPR_WIDTH + ELAPSED_WIDTH;

  localparam logic [CPR_WIDTH-1:0] CPR_RESET = CPR_WIDTH'(540);
  localparam logic [RPM_WIDTH-1:0] RPM_MAX   = '1;

  // Command codes
  localparam logic [CMD_WIDTH-1:0] CMD_TICK   = CMD_WIDTH'(0);
  localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE = CMD_WIDTH'(1);
  localparam logic [CMD_WIDTH-1:0] CMD_UPDATE = CMD_WIDTH'(2);

  typedef logic [COUNT_WIDTH-1:0]    count_t;
  typedef count_t [WHEELS-1:0]       counts_t;
  typedef logic [RPM_WIDTH-1:0]      rpm_t;

  // Control from the top level to the edge counter
  typedef struct packed {
    logic tick;
    logic sample;
    logic clear;
  } cnt_ctrl_t;

  typedef struct packed {
    rpm_t [WHEELS-1:0] rpm;
    logic              no_time_elapsed;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/fwet_if.sv
`default_nettype none

// Input channel: one command item
interface fwet_in_if;
  logic                           valid;
  logic                           ready;
  logic [fwet_pkg::CMD_WIDTH-1:0] cmd;
  logic [fwet_pkg::WHEELS-1:0]    levels;

  modport source (output valid, output cmd, output levels, input ready);
  modport sink   (input valid, input cmd, input levels, output ready);
endinterface

// Output channel: one speed report item
interface fwet_out_if;
  logic                 valid;
  logic                 ready;
  logic [fwet_pkg::RPM_WIDTH-1:0] rpm_front_right;
  logic [fwet_pkg::RPM_WIDTH-1:0] rpm_front_left;
  logic [fwet_pkg::RPM_WIDTH-1:0] rpm_back_right;
  logic [fwet_pkg::RPM_WIDTH-1:0] rpm_back_left;
  logic                 no_time_elapsed;

  modport source (output valid, output rpm_front_right, output rpm_front_left,
                  output rpm_back_right, output rpm_back_left,
                  output no_time_elapsed, input ready);
  modport sink   (input valid, input rpm_front_right, input rpm_front_left,
                  input rpm_back_right, input rpm_back_left,
                  input no_time_elapsed, output ready);
endinterface

`default_nettype wire

FILE: rtl/fwet_counter.sv
`default_nettype none

module fwet_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fwet_pkg::cnt_ctrl_t                 ctrl_i,
  input  logic [fwet_pkg::WHEELS-1:0]         levels_i,
  output fwet_pkg::counts_t                   counts_o,
  output logic [fwet_pkg::ELAPSED_WIDTH-1:0]  elapsed_o
);

  logic [fwet_pkg::WHEELS-1:0]        prev_q, prev_d;
  logic                               primed_q, primed_d;
  fwet_pkg::counts_t                  counts_q, counts_d;
  logic [fwet_pkg::ELAPSED_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [fwet_pkg::WHEELS-1:0]        changed;

  assign changed = levels_i ^ prev_q;

  // Count ticks and line changes, clear on update
  always_comb begin
    prev_d    = prev_q;
    primed_d  = primed_q;
    counts_d  = counts_q;
    elapsed_d = elapsed_q;
    if (ctrl_i.clear) begin
      counts_d  = '0;
      elapsed_d = '0;
    end
    if (ctrl_i.tick && (elapsed_q != '1)) begin
      elapsed_d = elapsed_q + 1'b1;
    end
    if (ctrl_i.sample) begin
      if (primed_q) begin
        for (int w = 0; w < fwet_pkg::WHEELS; w++) begin
          if (changed[w] && (counts_q[w] != '1)) begin
            counts_d[w] = counts_q[w] + 1'b1;
          end
        end
      end
      prev_d   = levels_i;
      primed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      primed_q  <= 1'b0;
      counts_q  <= '0;
      elapsed_q <= '0;
    end else begin
      prev_q    <= prev_d;
      primed_q  <= primed_d;
      counts_q  <= counts_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign counts_o  = counts_q;
  assign elapsed_o = elapsed_q;

endmodule

`default_nettype wire

FILE: rtl/fwet_divider.sv
`default_nettype none

module fwet_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  fwet_pkg::counts_t                   counts_i,
  input  logic [fwet_pkg::ELAPSED_WIDTH-1:0]  elapsed_i,
  input  logic [fwet_pkg::CPR_WIDTH-1:0]      cpr_i,
  input  logic                                take_i,
  output logic                                busy_o,
  output logic                                done_o,
  output fwet_pkg::result_t                   result_o
);

  localparam int WheelIdxW = $clog2(fwet_pkg::WHEELS);
  localparam int MulCntW   = $clog2(fwet_pkg::CPR_WIDTH);
  localparam int DivCntW   = $clog2(fwet_pkg::RPM_WIDTH);
  localparam int DenW      = fwet_pkg::DEN_WIDTH;
  localparam int RpmW      = fwet_pkg::RPM_WIDTH;
  localparam int NumW      = fwet_pkg::NUM_WIDTH;
  localparam int HiW       = fwet_pkg::HI_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                         state_q, state_d;
  fwet_pkg::counts_t                  counts_q, counts_d;
  logic [fwet_pkg::ELAPSED_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [fwet_pkg::CPR_WIDTH-1:0]     cpr_sr_q, cpr_sr_d;
  logic [DenW-1:0]                    den_q, den_d;
  logic [MulCntW-1:0]                 mcnt_q, mcnt_d;
  logic [WheelIdxW-1:0]               wheel_q, wheel_d;
  logic [NumW-1:0]                    num_q, num_d;
  logic [DenW-1:0]                    rem_q, rem_d;
  logic [RpmW-1:0]                    lo_q, lo_d;
  logic [RpmW-1:0]                    quot_q, quot_d;
  logic [DivCntW-1:0]                 dcnt_q, dcnt_d;
  fwet_pkg::rpm_t [fwet_pkg::WHEELS-1:0] res_q, res_d;
  logic                               zero_q, zero_d;

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            ge;
  logic            sat;
  logic            last_wheel;

  // One restoring division step: shift in the next numerator bit
  assign trial = {rem_q, lo_q[RpmW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Quotient reaches the limit when the upper numerator bits reach den
  assign sat        = ({{(DenW-HiW){1'b0}}, num_q[NumW-1:RpmW]} >= den_q);
  assign last_wheel = (wheel_q == WheelIdxW'(fwet_pkg::WHEELS - 1));

  always_comb begin
    state_d   = state_q;
    counts_d  = counts_q;
    elapsed_d = elapsed_q;
    cpr_sr_d  = cpr_sr_q;
    den_d     = den_q;
    mcnt_d    = mcnt_q;
    wheel_d   = wheel_q;
    num_d     = num_q;
    rem_d     = rem_q;
    lo_d      = lo_q;
    quot_d    = quot_q;
    dcnt_d    = dcnt_q;
    res_d     = res_q;
    zero_d    = zero_q;
    unique case (state_q)
      // Latch the snapshot; zero time skips straight to the report
      S_IDLE: begin
        if (start_i) begin
          counts_d  = counts_i;
          elapsed_d = elapsed_i;
          cpr_sr_d  = (cpr_i == '0) ? fwet_pkg::CPR_WIDTH'(1) : cpr_i;
          den_d     = '0;
          mcnt_d    = MulCntW'(fwet_pkg::CPR_WIDTH - 1);
          wheel_d   = '0;
          if (elapsed_i == '0) begin
            zero_d = 1'b1;
            for (int w = 0; w < fwet_pkg::WHEELS; w++) begin
              res_d[w] = fwet_pkg::RPM_MAX;
            end
            state_d = S_DONE;
          end else begin
            zero_d  = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      // Shift-add cpr * elapsed, one cpr bit per cycle
      S_MUL: begin
        den_d    = (den_q << 1) +
                   (cpr_sr_q[fwet_pkg::CPR_WIDTH-1] ? DenW'(elapsed_q) : '0);
        cpr_sr_d = cpr_sr_q << 1;
        if (mcnt_q == '0) begin
          state_d = S_NUM;
        end else begin
          mcnt_d = mcnt_q - 1'b1;
        end
      end
      // Scale this wheel's count
      S_NUM: begin
        num_d   = NumW'(counts_q[wheel_q]) * NumW'(fwet_pkg::SCALE);
        state_d = S_CHK;
      end
      // Saturate early, else set up the remainder
      S_CHK: begin
        if (sat) begin
          res_d[wheel_q] = fwet_pkg::RPM_MAX;
          if (last_wheel) begin
            state_d = S_DONE;
          end else begin
            wheel_d = wheel_q + 1'b1;
            state_d = S_NUM;
          end
        end else begin
          rem_d   = DenW'(num_q[NumW-1:RpmW]);
          lo_d    = num_q[RpmW-1:0];
          dcnt_d  = DivCntW'(RpmW - 1);
          state_d = S_DIV;
        end
      end
      // One quotient bit per cycle
      S_DIV: begin
        rem_d  = ge ? diff[DenW-1:0] : trial[DenW-1:0];
        lo_d   = lo_q << 1;
        quot_d = {quot_q[RpmW-2:0], ge};
        if (dcnt_q == '0) begin
          res_d[wheel_q] = quot_d;
          if (last_wheel) begin
            state_d = S_DONE;
          end else begin
            wheel_d = wheel_q + 1'b1;
            state_d = S_NUM;
          end
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      // Hold the report until the output register takes it
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    counts_q  <= counts_d;
    elapsed_q <= elapsed_d;
    cpr_sr_q  <= cpr_sr_d;
    den_q     <= den_d;
    mcnt_q    <= mcnt_d;
    wheel_q   <= wheel_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    lo_q      <= lo_d;
    quot_q    <= quot_d;
    dcnt_q    <= dcnt_d;
    res_q     <= res_d;
    zero_q    <= zero_d;
  end

  assign busy_o                   = (state_q != S_IDLE);
  assign done_o                   = (state_q == S_DONE);
  assign result_o.rpm             = res_q;
  assign result_o.no_time_elapsed = zero_q;

endmodule

`default_nettype wire

FILE: rtl/four_wheel_encoder_tachometer.sv
// Four-wheel encoder tachometer.
// Input channel in_i carries one command item: a millisecond tick, a sample
// of the four encoder lines (bit0 front right .. bit3 back left), or an
// update. Ticks and samples give no output. An update snapshots the edge
// counts and elapsed time, clears both, and produces one item on out_o with
// each wheel's speed in RPM * 16. The update runs a serial cpr * elapsed
// multiply, then per wheel one scaling step, one saturation check and a
// bit-serial division (skipped when a wheel saturates), then loads the
// output register; with zero elapsed time it goes straight to loading the
// output register. in_i.ready stays low until the result has left the
// divider, so no new item is taken while an update is being computed.
// cfg_we_i/cfg_data_i write clicks_per_rev; write it only while idle.
// Reset clears counts, elapsed time, primed state and output valid, and
// loads clicks_per_rev with 540. A stalled receiver holds the result in
// the output register; ticks and samples keep being accepted meanwhile, and
// a second update finishes computing and then waits for the register.
`default_nettype none

module four_wheel_encoder_tachometer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fwet_in_if.sink                         in_i,
  fwet_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [fwet_pkg::CPR_WIDTH-1:0]  cfg_data_i
);

  logic [fwet_pkg::CPR_WIDTH-1:0]     cpr_q;
  logic                               accept;
  logic                               busy;
  logic                               done;
  logic                               take;
  fwet_pkg::cnt_ctrl_t                ctrl;
  fwet_pkg::counts_t                  counts;
  logic [fwet_pkg::ELAPSED_WIDTH-1:0] elapsed;
  fwet_pkg::result_t                  result;
  logic                               out_valid_q, out_valid_d;
  fwet_pkg::result_t                  out_res_q;

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && !busy;

  // Decode the command
  assign ctrl.tick   = accept && (in_i.cmd == fwet_pkg::CMD_TICK);
  assign ctrl.sample = accept && (in_i.cmd == fwet_pkg::CMD_SAMPLE);
  assign ctrl.clear  = accept && (in_i.cmd == fwet_pkg::CMD_UPDATE);

  // Hold clicks_per_rev
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= fwet_pkg::CPR_RESET;
    end else if (cfg_we_i) begin
      cpr_q <= cfg_data_i;
    end
  end

  fwet_counter u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .levels_i  (in_i.levels),
    .counts_o  (counts),
    .elapsed_o (elapsed)
  );

  fwet_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.clear),
    .counts_i  (counts),
    .elapsed_i (elapsed),
    .cpr_i     (cpr_q),
    .take_i    (take),
    .busy_o    (busy),
    .done_o    (done),
    .result_o  (result)
  );

  // Output register: load a finished result once the slot is free
  assign take = done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= result;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.rpm_front_right = out_res_q.rpm[0];
  assign out_o.rpm_front_left  = out_res_q.rpm[1];
  assign out_o.rpm_back_right  = out_res_q.rpm[2];
  assign out_o.rpm_back_left   = out_res_q.rpm[3];
  assign out_o.no_time_elapsed = out_res_q.no_time_elapsed;

endmodule

`default_nettype wire
